// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the core RTL.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("core assertion failed");

// next-cycle implication
`define PTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("core assertion failed");

`endif

// ===== rtl/core/ptt_pkg.sv =====
// Types and constants of the periodic task timer table.
// No dependencies.
package ptt_pkg;

  localparam int HANDLE_W  = 8;
  localparam int TIME_W    = 32;
  localparam int PEND_W    = 8;
  localparam int FOUND_W   = 4;
  localparam logic [FOUND_W-1:0] RESULT_CAP = 4'd8;
  localparam logic [PEND_W-1:0]  PEND_MAX   = 8'd255;

  localparam logic [1:0] FUNC_ADD      = 2'd0;
  localparam logic [1:0] FUNC_DELETE   = 2'd1;
  localparam logic [1:0] FUNC_TICK     = 2'd2;
  localparam logic [1:0] FUNC_DISPATCH = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   delay;
    logic [TIME_W-1:0]   period;
    logic [PEND_W-1:0]   pending;
  } entry_t;

  typedef struct packed {
    entry_t data;
    logic   found;
  } upd_t;

endpackage

// ===== rtl/core/ptt_table_mem.sv =====
// Task table storage: one write port, one read port, registered read data.
// Depends on ptt_pkg.
module ptt_table_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  ptt_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output ptt_pkg::entry_t rdata_o
);
  import ptt_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ptt_slot_alu.sv =====
// Read-modify step for one table entry during a tick or dispatch walk.
// Depends on ptt_pkg.
module ptt_slot_alu (
  input  logic [1:0]                  func_i,
  input  ptt_pkg::entry_t             rd_i,
  input  logic [ptt_pkg::FOUND_W-1:0] found_i,
  output ptt_pkg::upd_t               upd_o
);
  import ptt_pkg::*;

  logic [TIME_W-1:0] dly;

  always_comb begin
    dly   = rd_i.delay;
    upd_o = '{data: rd_i, found: 1'b0};
    case (func_i)
      FUNC_TICK: begin
        if (dly != '0) begin
          dly = dly - 1'b1;
        end
        if (dly == '0) begin
          dly = rd_i.period;
          if (rd_i.pending != PEND_MAX) begin
            upd_o.data.pending = rd_i.pending + 1'b1;
          end
        end
        upd_o.data.delay = dly;
      end
      FUNC_DISPATCH: begin
        if (rd_i.pending != '0 && found_i < RESULT_CAP) begin
          upd_o.found        = 1'b1;
          upd_o.data.pending = rd_i.pending - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/periodic_task_timer_table_core.sv =====
// Add and rejected items go from idle straight to the response state and wait there for the
// output register. Tick and dispatch walk the occupied slots through the table's single read
// port, one slot per cycle; dispatch pauses whenever a result word is not taken. Delete moves
// each later slot down one per cycle. Depends on ptt_pkg, ptt_table_mem, ptt_slot_alu and
// assert_macros.svh.
`include "assert_macros.svh"

module periodic_task_timer_table_core #(
  parameter int MAX_TASKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  task_handle_i,
  input  logic [31:0] first_delay_i,
  input  logic [31:0] reload_period_i,
  input  logic [2:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        run_valid_o,
  output logic [7:0]  run_handle_o,
  output logic [2:0]  run_slot_o,
  output logic [1:0]  status_o,
  output logic [3:0]  tasks_in_use_o,
  output logic        last_o
);
  import ptt_pkg::*;

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e              state_q;
  logic [1:0]          func_q;
  logic [CW-1:0]       cnt_q;
  logic [CW-1:0]       ra_q;
  logic [CW-1:0]       end_q;
  logic                dv_q;
  logic [SW-1:0]       da_q;
  logic [FOUND_W-1:0]  found_q;
  logic                hold_v_q;
  logic [HANDLE_W-1:0] hold_h_q;
  logic [SW-1:0]       hold_s_q;
  logic [1:0]          status_q;
  logic                out_v_q;
  logic                out_rv_q;
  logic [7:0]          out_h_q;
  logic [2:0]          out_s_q;
  logic [1:0]          out_st_q;
  logic [3:0]          out_cnt_q;
  logic                out_last_q;

  logic          in_acc, out_free, need_push, walk_hold, issue, walk_done, resp_push;
  logic          full, slot_bad;
  logic          we;
  logic [SW-1:0] waddr;
  entry_t        wdata, rdata;
  upd_t          upd;
  logic [SW+2:0] slot_ext;
  logic [CW+3:0] cnt_ext;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_v_q || !out_stall_i;
  assign need_push = (state_q == ST_WALK) && dv_q && (func_q == FUNC_DISPATCH) &&
                     upd.found && hold_v_q;
  assign walk_hold = need_push && !out_free;
  assign issue     = (state_q == ST_WALK) && !walk_hold && (ra_q < end_q);
  assign walk_done = (state_q == ST_WALK) && !dv_q && (ra_q >= end_q);
  assign resp_push = (state_q == ST_RESP) && out_free;
  assign full      = (cnt_q >= CW'(MAX_TASKS));
  assign slot_bad  = ({{CW{1'b0}}, slot_index_i} >= {3'b000, cnt_q});
  assign slot_ext  = {3'b000, hold_s_q};
  assign cnt_ext   = {4'b0000, cnt_q};

  ptt_slot_alu u_alu (
    .func_i  (func_q),
    .rd_i    (rdata),
    .found_i (found_q),
    .upd_o   (upd)
  );

  always_comb begin
    we    = 1'b0;
    waddr = da_q;
    wdata = upd.data;
    if (in_acc && func_i == FUNC_ADD) begin
      we    = 1'b1;
      waddr = full ? SW'(MAX_TASKS - 1) : cnt_q[SW-1:0];
      wdata = '{handle: task_handle_i, delay: first_delay_i, period: reload_period_i,
                pending: '0};
    end else if ((state_q == ST_WALK) && dv_q && !walk_hold) begin
      we    = 1'b1;
      waddr = (func_q == FUNC_DELETE) ? da_q - 1'b1 : da_q;
    end
  end

  ptt_table_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (SW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (ra_q[SW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      func_q   <= FUNC_ADD;
      cnt_q    <= '0;
      ra_q     <= '0;
      end_q    <= '0;
      dv_q     <= 1'b0;
      da_q     <= '0;
      found_q  <= '0;
      hold_v_q <= 1'b0;
      hold_h_q <= '0;
      hold_s_q <= '0;
      status_q <= STATUS_OK;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            func_q   <= func_i;
            status_q <= STATUS_OK;
            dv_q     <= 1'b0;
            found_q  <= '0;
            hold_v_q <= 1'b0;
            hold_h_q <= '0;
            hold_s_q <= '0;
            case (func_i)
              FUNC_ADD: begin
                if (full) begin
                  status_q <= STATUS_FULL;
                end else begin
                  cnt_q <= cnt_q + 1'b1;
                end
                state_q <= ST_RESP;
              end
              FUNC_DELETE: begin
                if (slot_bad) begin
                  status_q <= STATUS_BAD;
                  state_q  <= ST_RESP;
                end else begin
                  ra_q    <= CW'(slot_index_i) + 1'b1;
                  end_q   <= cnt_q;
                  state_q <= ST_WALK;
                end
              end
              default: begin
                if (cnt_q == '0) begin
                  status_q <= STATUS_BAD;
                  state_q  <= ST_RESP;
                end else begin
                  ra_q    <= '0;
                  end_q   <= cnt_q;
                  state_q <= ST_WALK;
                end
              end
            endcase
          end
        end
        ST_WALK: begin
          if (issue) begin
            ra_q <= ra_q + 1'b1;
          end
          if (!walk_hold) begin
            dv_q <= issue;
            da_q <= ra_q[SW-1:0];
            if (dv_q && upd.found) begin
              found_q  <= found_q + 1'b1;
              hold_v_q <= 1'b1;
              hold_h_q <= rdata.handle;
              hold_s_q <= da_q;
            end
          end
          if (walk_done) begin
            if (func_q == FUNC_DELETE) begin
              cnt_q <= cnt_q - 1'b1;
            end
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (resp_push) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q    <= 1'b0;
      out_rv_q   <= 1'b0;
      out_h_q    <= '0;
      out_s_q    <= '0;
      out_st_q   <= STATUS_OK;
      out_cnt_q  <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if ((need_push && out_free) || resp_push) begin
        out_v_q    <= 1'b1;
        out_rv_q   <= hold_v_q;
        out_h_q    <= hold_h_q;
        out_s_q    <= slot_ext[2:0];
        out_st_q   <= resp_push ? status_q : STATUS_OK;
        out_cnt_q  <= cnt_ext[3:0];
        out_last_q <= resp_push;
      end
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_v_q;
  assign run_valid_o    = out_rv_q;
  assign run_handle_o   = out_h_q;
  assign run_slot_o     = out_s_q;
  assign status_o       = out_st_q;
  assign tasks_in_use_o = out_cnt_q;
  assign last_o         = out_last_q;

  `PTT_ASSERT_IMPL(a_cnt_in_range, 1'b1, cnt_q <= CW'(MAX_TASKS))
  `PTT_ASSERT_IMPL(a_idle_drained, state_q == ST_IDLE, !dv_q)
  `PTT_ASSERT_IMPL(a_found_capped, 1'b1, found_q <= RESULT_CAP)
  `PTT_ASSERT_NEXT(a_resp_clears, resp_push, state_q == ST_IDLE && out_v_q && out_last_q)

endmodule
